### sv/fm_note_on_register_sequencer_top_assert.svh
// Assertion macros used by the FM note-on register sequencer top level.
`ifndef FM_NOTE_ON_REGISTER_SEQUENCER_TOP_ASSERT_SVH
`define FM_NOTE_ON_REGISTER_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FMNOTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FMNOTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fmnote_pkg.sv
// Types, constants and lookup tables of the FM note-on register sequencer.
package fmnote_pkg;

  localparam logic [39:0] ModPatchRst = 40'h1114F4C800;
  localparam logic [39:0] CarPatchRst = 40'h2100F3C600;
  localparam logic [7:0]  FbConnRst   = 8'h0E;
  localparam logic [3:0]  VoiceChRst  = 4'd4;

  localparam logic [3:0] MaxChannel = 4'd8;
  localparam logic [6:0] LowestNote = 7'd12;
  localparam logic [2:0] MaxBlock   = 3'd7;
  localparam logic [7:0] CarOffset  = 8'h03;

  // Register base addresses of the synthesizer.
  localparam logic [7:0] AddrMult    = 8'h20;
  localparam logic [7:0] AddrLevel   = 8'h40;
  localparam logic [7:0] AddrAtkDec  = 8'h60;
  localparam logic [7:0] AddrSusRel  = 8'h80;
  localparam logic [7:0] AddrFnumLo  = 8'hA0;
  localparam logic [7:0] AddrKeyOn   = 8'hB0;
  localparam logic [7:0] AddrFbConn  = 8'hC0;
  localparam logic [7:0] AddrWave    = 8'hE0;

  typedef enum logic [1:0] {
    REG_MOD_PATCH = 2'd0,
    REG_CAR_PATCH = 2'd1,
    REG_FB_CONN   = 2'd2,
    REG_VOICE_CH  = 2'd3
  } cfg_reg_e;

  // One step per register write of a note-on run.
  typedef enum logic [3:0] {
    STEP_KEY_OFF  = 4'd0,
    STEP_MULT_MOD = 4'd1,
    STEP_MULT_CAR = 4'd2,
    STEP_LVL_MOD  = 4'd3,
    STEP_LVL_CAR  = 4'd4,
    STEP_AD_MOD   = 4'd5,
    STEP_AD_CAR   = 4'd6,
    STEP_SR_MOD   = 4'd7,
    STEP_SR_CAR   = 4'd8,
    STEP_WAVE_MOD = 4'd9,
    STEP_WAVE_CAR = 4'd10,
    STEP_FB_CONN  = 4'd11,
    STEP_VOLUME   = 4'd12,
    STEP_FNUM_LO  = 4'd13,
    STEP_KEY_ON   = 4'd14
  } step_e;

  typedef struct packed {
    logic [39:0] mod_patch;
    logic [39:0] car_patch;
    logic [7:0]  fb_conn;
  } cfg_t;

  // Per-note values, worked out once when the note enters the sequencer.
  typedef struct packed {
    logic [3:0] channel;
    logic [2:0] block;
    logic [9:0] fnum;
    logic [5:0] volume;
  } note_t;

  function automatic logic [7:0] mod_slot(input logic [3:0] ch);
    logic [7:0] slot;
    case (ch)
      4'd0:    slot = 8'h00;
      4'd1:    slot = 8'h01;
      4'd2:    slot = 8'h02;
      4'd3:    slot = 8'h08;
      4'd4:    slot = 8'h09;
      4'd5:    slot = 8'h0A;
      4'd6:    slot = 8'h10;
      4'd7:    slot = 8'h11;
      default: slot = 8'h12;
    endcase
    return slot;
  endfunction

  function automatic logic [9:0] fnum_lut(input logic [3:0] semi);
    logic [9:0] f;
    case (semi)
      4'd0:    f = 10'd308;
      4'd1:    f = 10'd325;
      4'd2:    f = 10'd345;
      4'd3:    f = 10'd365;
      4'd4:    f = 10'd387;
      4'd5:    f = 10'd410;
      4'd6:    f = 10'd434;
      4'd7:    f = 10'd460;
      4'd8:    f = 10'd487;
      4'd9:    f = 10'd516;
      4'd10:   f = 10'd547;
      default: f = 10'd579;
    endcase
    return f;
  endfunction

endpackage

### sv/fmnote_wr_gen.sv
// Register address and data of one write step of a note-on run.
module fmnote_wr_gen (
  input  fmnote_pkg::cfg_t  cfg_i,
  input  fmnote_pkg::note_t note_i,
  input  fmnote_pkg::step_e step_i,
  input  logic [4:0]        shadow_i,
  output logic [7:0]        reg_addr_o,
  output logic [7:0]        reg_data_o,
  output logic              last_write_o
);

  logic [7:0] ch_w;
  logic [7:0] mod_w;
  logic [7:0] car_w;
  logic [7:0] key_on_w;

  assign ch_w     = {4'd0, note_i.channel};
  assign mod_w    = fmnote_pkg::mod_slot(note_i.channel);
  assign car_w    = mod_w + fmnote_pkg::CarOffset;
  assign key_on_w = {3'b001, note_i.block, note_i.fnum[9:8]};

  always_comb begin
    reg_addr_o   = fmnote_pkg::AddrKeyOn + ch_w;
    reg_data_o   = {3'd0, shadow_i};
    last_write_o = 1'b0;
    case (step_i)
      fmnote_pkg::STEP_KEY_OFF: begin
        reg_addr_o = fmnote_pkg::AddrKeyOn + ch_w;
        reg_data_o = {3'd0, shadow_i};
      end
      fmnote_pkg::STEP_MULT_MOD: begin
        reg_addr_o = fmnote_pkg::AddrMult + mod_w;
        reg_data_o = cfg_i.mod_patch[39:32];
      end
      fmnote_pkg::STEP_MULT_CAR: begin
        reg_addr_o = fmnote_pkg::AddrMult + car_w;
        reg_data_o = cfg_i.car_patch[39:32];
      end
      fmnote_pkg::STEP_LVL_MOD: begin
        reg_addr_o = fmnote_pkg::AddrLevel + mod_w;
        reg_data_o = cfg_i.mod_patch[31:24];
      end
      fmnote_pkg::STEP_LVL_CAR: begin
        reg_addr_o = fmnote_pkg::AddrLevel + car_w;
        reg_data_o = cfg_i.car_patch[31:24];
      end
      fmnote_pkg::STEP_AD_MOD: begin
        reg_addr_o = fmnote_pkg::AddrAtkDec + mod_w;
        reg_data_o = cfg_i.mod_patch[23:16];
      end
      fmnote_pkg::STEP_AD_CAR: begin
        reg_addr_o = fmnote_pkg::AddrAtkDec + car_w;
        reg_data_o = cfg_i.car_patch[23:16];
      end
      fmnote_pkg::STEP_SR_MOD: begin
        reg_addr_o = fmnote_pkg::AddrSusRel + mod_w;
        reg_data_o = cfg_i.mod_patch[15:8];
      end
      fmnote_pkg::STEP_SR_CAR: begin
        reg_addr_o = fmnote_pkg::AddrSusRel + car_w;
        reg_data_o = cfg_i.car_patch[15:8];
      end
      fmnote_pkg::STEP_WAVE_MOD: begin
        reg_addr_o = fmnote_pkg::AddrWave + mod_w;
        reg_data_o = cfg_i.mod_patch[7:0];
      end
      fmnote_pkg::STEP_WAVE_CAR: begin
        reg_addr_o = fmnote_pkg::AddrWave + car_w;
        reg_data_o = cfg_i.car_patch[7:0];
      end
      fmnote_pkg::STEP_FB_CONN: begin
        reg_addr_o = fmnote_pkg::AddrFbConn + ch_w;
        reg_data_o = cfg_i.fb_conn;
      end
      fmnote_pkg::STEP_VOLUME: begin
        // Keep the carrier's key scale bits, replace the attenuation.
        reg_addr_o = fmnote_pkg::AddrLevel + car_w;
        reg_data_o = {cfg_i.car_patch[31:30], note_i.volume};
      end
      fmnote_pkg::STEP_FNUM_LO: begin
        reg_addr_o = fmnote_pkg::AddrFnumLo + ch_w;
        reg_data_o = note_i.fnum[7:0];
      end
      fmnote_pkg::STEP_KEY_ON: begin
        reg_addr_o   = fmnote_pkg::AddrKeyOn + ch_w;
        reg_data_o   = key_on_w;
        last_write_o = 1'b1;
      end
      default: begin
        reg_addr_o   = fmnote_pkg::AddrKeyOn + ch_w;
        reg_data_o   = {3'd0, shadow_i};
        last_write_o = 1'b0;
      end
    endcase
  end

endmodule

### sv/fm_note_on_register_sequencer_top.sv
// Top level of the FM note-on register sequencer: stream ports, APB registers, write sequencing.
// Each note item yields fifteen write items, which pass the input, sequencer and output registers.
// The single output register carries one write per cycle while the master side is ready, and
// a waiting note is held in the input register so runs follow without a gap.
// Reset (rst_ni low, asynchronous) empties the input, sequencer and output stages, clears the key-off shadow
// and loads the patch, feedback and channel registers with their default values.
module fm_note_on_register_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Note items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [6:0] note number, [13:7] note_velocity, [15:14] zero
  // Register-write items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] reg_addr, [15:8] reg_data
  output logic        m_axis_tlast,   // last_write: the key-on write that ends a run
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Each register sits at byte address 8*index, so the
  // index is paddr[4:3]. Writes happen on the access phase of the transfer.
  // ---------------------------------------------------------------------------
  logic [39:0]         mod_patch_q;
  logic [39:0]         car_patch_q;
  logic [7:0]          fb_conn_q;
  logic [3:0]          voice_ch_q;
  logic                cfg_wr;
  fmnote_pkg::cfg_reg_e cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = fmnote_pkg::cfg_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_patch_q <= fmnote_pkg::ModPatchRst;
      car_patch_q <= fmnote_pkg::CarPatchRst;
      fb_conn_q   <= fmnote_pkg::FbConnRst;
      voice_ch_q  <= fmnote_pkg::VoiceChRst;
    end else if (cfg_wr) begin
      case (cfg_sel)
        fmnote_pkg::REG_MOD_PATCH: mod_patch_q <= pwdata[39:0];
        fmnote_pkg::REG_CAR_PATCH: car_patch_q <= pwdata[39:0];
        fmnote_pkg::REG_FB_CONN:   fb_conn_q   <= pwdata[7:0];
        fmnote_pkg::REG_VOICE_CH:  voice_ch_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      fmnote_pkg::REG_MOD_PATCH: prdata = {24'd0, mod_patch_q};
      fmnote_pkg::REG_CAR_PATCH: prdata = {24'd0, car_patch_q};
      fmnote_pkg::REG_FB_CONN:   prdata = {56'd0, fb_conn_q};
      fmnote_pkg::REG_VOICE_CH:  prdata = {60'd0, voice_ch_q};
      default:                   prdata = 64'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. A note item waits here while the previous run is still
  // being written out, so the slave side never has to wait on the master side
  // for more than the run itself.
  // ---------------------------------------------------------------------------
  logic       hold_valid_q, hold_valid_d;
  logic [6:0] hold_note_q;
  logic [6:0] hold_vel_q;
  logic       in_acc;

  assign s_axis_tready = !hold_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Per-note values: clamp the note, split it into octave block and semitone,
  // look up the F-number and form the carrier attenuation. The divide by
  // twelve is a multiply by 171/2048, exact for the 0..115 range seen here.
  // ---------------------------------------------------------------------------
  logic [6:0]        note_clamp;
  logic [6:0]        note_ofs;
  logic [14:0]       div_prod;
  logic [3:0]        octave;
  logic [6:0]        octave_x12;
  logic [6:0]        semi_full;
  fmnote_pkg::note_t note_new;

  always_comb begin
    note_clamp = (hold_note_q < fmnote_pkg::LowestNote) ? fmnote_pkg::LowestNote
                                                         : hold_note_q;
    note_ofs   = note_clamp - fmnote_pkg::LowestNote;
    div_prod   = {8'd0, note_ofs} * 15'd171;
    octave     = div_prod[14:11];
    octave_x12 = {octave, 3'd0} + {1'b0, octave, 2'd0};
    semi_full  = note_ofs - octave_x12;

    note_new.channel = (voice_ch_q > fmnote_pkg::MaxChannel) ? fmnote_pkg::MaxChannel
                                                              : voice_ch_q;
    note_new.block   = (octave > {1'b0, fmnote_pkg::MaxBlock}) ? fmnote_pkg::MaxBlock
                                                                : octave[2:0];
    note_new.fnum    = fmnote_pkg::fnum_lut(semi_full[3:0]);
    note_new.volume  = 6'd63 - hold_vel_q[6:1];
  end

  // ---------------------------------------------------------------------------
  // Sequencer stage: the current note and its step counter. Each step loads
  // one write item into the output register when that register is free or
  // being drained. The key-on step ends the run and updates the shadow that
  // the next run's key-off replays.
  // ---------------------------------------------------------------------------
  logic                cur_active_q, cur_active_d;
  fmnote_pkg::note_t   cur_note_q;
  fmnote_pkg::step_e   step_q, step_d;
  logic [4:0]          shadow_q, shadow_d;
  logic                out_free;
  logic                step_go;
  logic                run_done;
  logic                cur_load;

  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_addr_q;
  logic [7:0]          out_data_q;
  logic                out_last_q;

  logic [7:0]          wr_addr;
  logic [7:0]          wr_data;
  logic                wr_last;
  fmnote_pkg::cfg_t    cfg_bus;

  assign cfg_bus.mod_patch = mod_patch_q;
  assign cfg_bus.car_patch = car_patch_q;
  assign cfg_bus.fb_conn   = fb_conn_q;

  fmnote_wr_gen u_wr_gen (
    .cfg_i       (cfg_bus),
    .note_i      (cur_note_q),
    .step_i      (step_q),
    .shadow_i    (shadow_q),
    .reg_addr_o  (wr_addr),
    .reg_data_o  (wr_data),
    .last_write_o(wr_last)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign step_go  = cur_active_q && out_free;
  assign run_done = step_go && (step_q == fmnote_pkg::STEP_KEY_ON);
  assign cur_load = hold_valid_q && (!cur_active_q || run_done);

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (cur_load) begin
      hold_valid_d = 1'b0;
    end
    if (in_acc) begin
      hold_valid_d = 1'b1;
    end

    cur_active_d = cur_active_q;
    step_d       = step_q;
    shadow_d     = shadow_q;
    if (step_go) begin
      step_d = fmnote_pkg::step_e'(step_q + 4'd1);
    end
    if (run_done) begin
      cur_active_d = 1'b0;
      step_d       = fmnote_pkg::STEP_KEY_OFF;
      shadow_d     = wr_data[4:0];
    end
    if (cur_load) begin
      cur_active_d = 1'b1;
      step_d       = fmnote_pkg::STEP_KEY_OFF;
    end

    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = cur_active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      cur_active_q <= 1'b0;
      step_q       <= fmnote_pkg::STEP_KEY_OFF;
      shadow_q     <= 5'd0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      cur_active_q <= cur_active_d;
      step_q       <= step_d;
      shadow_q     <= shadow_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_note_q <= s_axis_tdata[6:0];
      hold_vel_q  <= s_axis_tdata[13:7];
    end
    if (cur_load) begin
      cur_note_q <= note_new;
    end
    if (step_go) begin
      out_addr_q <= wr_addr;
      out_data_q <= wr_data;
      out_last_q <= wr_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
`include "fm_note_on_register_sequencer_top_assert.svh"

  `FMNOTE_ASSERT_NEXT(a_key_on_ends_run, run_done, out_valid_q && out_last_q, "key-on lost")
  `FMNOTE_ASSERT_NOW(a_last_is_key_on, out_valid_q && out_last_q, out_addr_q[7:4] == 4'hB, "bad last")
  `FMNOTE_ASSERT_NEXT(a_waiting_note_starts, hold_valid_q && !cur_active_q, cur_active_q, "note stuck")
  `FMNOTE_ASSERT_NEXT(a_shadow_follows_key_on, run_done, shadow_q == out_data_q[4:0], "shadow lag")

endmodule
